// ===== hdl/wsd_pkg.sv =====
`default_nettype none

package wsd_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// Parser phases, one-hot
	typedef enum logic [5:0] {
		PH_FIRST   = 6'b000001,
		PH_SECOND  = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_HALTED  = 6'b100000
	} phase_t;

	localparam logic [7:0] MASK_BIT     = 8'h80;
	localparam logic [3:0] OPCODE_MASK  = 4'hF;
	localparam logic [6:0] LEN7_MAX     = 7'd125;
	localparam logic [6:0] LEN7_EXT16   = 7'd126;
	localparam logic [6:0] LEN7_EXT64   = 7'd127;
	localparam logic [2:0] EXT16_BYTES  = 3'd2;
	localparam logic [2:0] EXT64_WRAP   = 3'd0;
	localparam logic [2:0] KEY_BYTES    = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame deframer for client-to-server frames.
// Input channel (byte_valid/byte_ready): one link byte per beat, with
// new_connection marking a beat that restarts parsing; that beat's byte is
// taken as the first header byte of a fresh frame.
// Output channel (result_valid/result_ready): at most one result per input
// beat. Payload bytes come out unmasked (kind payload), a zero-length frame
// gives one empty-frame result, and an unmasked frame gives one error result,
// after which all bytes are dropped until new_connection.
// Other header, extended-length and masking-key beats give no result.
// Timing: a beat is registered in the input stage, parsed against the frame
// state combinationally and lands in the result register, where result_valid
// rises. Throughput is one beat per cycle while the receiver takes results or
// the beat makes no result, set by the combinational parse step (64-bit
// length decrement and compare).
// Reset puts the parser at a frame start with both stages empty.
// When the receiver stalls, the result register holds; beats that make no
// result keep flowing, and a beat that makes a result waits in the input
// stage, which backs up byte_ready.
`default_nettype none

module websocket_frame_deframer #(
	parameter int LENGTH_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic        new_connection,
	input  wire logic [7:0]  link_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic             fin,
	output logic [3:0]       opcode,
	output logic             last,
	output logic [63:0]      frame_length
);

	localparam int LW = LENGTH_BITS;

	// Input stage
	logic       byte_valid_s1;
	logic       new_connection_s1;
	logic [7:0] link_byte_s1;

	// Frame state
	wsd_pkg::phase_t phase_q, phase_d, phase_eff;
	logic          final_flag_q, final_flag_d;
	logic [3:0]    frame_code_q, frame_code_d;
	logic [2:0]    hdr_count_q, hdr_count_d, hdr_count_inc;
	logic          ext_wide_q, ext_wide_d;
	logic [LW-1:0] payload_length_q, payload_length_d;
	logic [LW-1:0] bytes_remaining_q, bytes_remaining_d;
	logic [31:0]   mask_key_q, mask_key_d;
	logic [1:0]    mask_pos_q, mask_pos_d;

	// Result stage
	logic              result_valid_s2;
	wsd_pkg::kind_t    kind_s2;
	logic [7:0]        payload_byte_s2;
	logic              fin_s2;
	logic [3:0]        opcode_s2;
	logic              last_s2;
	logic [63:0]       frame_length_s2;

	// Parse outcome for the beat in the input stage
	logic           res_hit;
	wsd_pkg::kind_t res_kind;
	logic [7:0]     res_byte;
	logic           res_last;
	logic [63:0]    res_length;
	logic [6:0]     len7;
	logic [7:0]     key_byte;
	logic           out_free;
	logic           advance_s1;

	assign out_free   = !result_valid_s2 || result_ready;
	assign advance_s1 = byte_valid_s1 && (out_free || !res_hit);
	assign byte_ready = !byte_valid_s1 || advance_s1;

	assign len7          = link_byte_s1[6:0];
	assign hdr_count_inc = hdr_count_q + 3'd1;
	assign phase_eff     = new_connection_s1 ? wsd_pkg::PH_FIRST : phase_q;

	always_comb begin
		// Pick the key byte for this payload position, first key byte at 31:24
		case (mask_pos_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d           = phase_eff;
		final_flag_d      = final_flag_q;
		frame_code_d      = frame_code_q;
		hdr_count_d       = hdr_count_q;
		ext_wide_d        = ext_wide_q;
		payload_length_d  = payload_length_q;
		bytes_remaining_d = bytes_remaining_q;
		mask_key_d        = mask_key_q;
		mask_pos_d        = mask_pos_q;
		res_hit           = 1'b0;
		res_kind          = wsd_pkg::KIND_PAYLOAD;
		res_byte          = 8'd0;
		res_last          = 1'b0;
		res_length        = 64'd0;

		case (phase_eff)
			wsd_pkg::PH_SECOND: begin
				hdr_count_d = 3'd0;
				if ((link_byte_s1 & wsd_pkg::MASK_BIT) == 8'd0) begin
					phase_d  = wsd_pkg::PH_HALTED;
					res_hit  = 1'b1;
					res_kind = wsd_pkg::KIND_ERROR;
					res_last = 1'b1;
				end else if (len7 <= wsd_pkg::LEN7_MAX) begin
					payload_length_d = LW'(len7);
					phase_d          = wsd_pkg::PH_KEY;
				end else begin
					payload_length_d = '0;
					ext_wide_d       = (len7 == wsd_pkg::LEN7_EXT64);
					phase_d          = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				// Shift in big-endian; bytes beyond LW bits fall off the top
				payload_length_d = {payload_length_q[LW-9:0], link_byte_s1};
				hdr_count_d      = hdr_count_inc;
				if (hdr_count_inc == (ext_wide_q ? wsd_pkg::EXT64_WRAP
						: wsd_pkg::EXT16_BYTES)) begin
					hdr_count_d = 3'd0;
					phase_d     = wsd_pkg::PH_KEY;
				end
			end
			wsd_pkg::PH_KEY: begin
				mask_key_d  = {mask_key_q[23:0], link_byte_s1};
				hdr_count_d = hdr_count_inc;
				if (hdr_count_inc == wsd_pkg::KEY_BYTES) begin
					hdr_count_d       = 3'd0;
					bytes_remaining_d = payload_length_q;
					mask_pos_d        = 2'd0;
					if (payload_length_q == '0) begin
						phase_d  = wsd_pkg::PH_FIRST;
						res_hit  = 1'b1;
						res_kind = wsd_pkg::KIND_EMPTY;
						res_last = 1'b1;
					end else begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				bytes_remaining_d = bytes_remaining_q - LW'(1);
				mask_pos_d        = mask_pos_q + 2'd1;
				res_hit           = 1'b1;
				res_kind          = wsd_pkg::KIND_PAYLOAD;
				res_byte          = link_byte_s1 ^ key_byte;
				res_last          = (bytes_remaining_d == '0);
				res_length        = 64'(payload_length_q);
				if (res_last) begin
					phase_d = wsd_pkg::PH_FIRST;
				end
			end
			wsd_pkg::PH_HALTED: begin
				// Drop everything until a new connection
				phase_d = wsd_pkg::PH_HALTED;
			end
			default: begin
				// Frame start, also recovers from any stray phase code
				final_flag_d = link_byte_s1[7];
				frame_code_d = link_byte_s1[3:0] & wsd_pkg::OPCODE_MASK;
				phase_d      = wsd_pkg::PH_SECOND;
			end
		endcase
	end

	// Input stage: load on every free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			new_connection_s1 <= new_connection;
			link_byte_s1      <= link_byte;
		end
	end

	// Frame state: advance once per parsed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= wsd_pkg::PH_FIRST;
			final_flag_q      <= 1'b0;
			frame_code_q      <= 4'd0;
			hdr_count_q       <= 3'd0;
			ext_wide_q        <= 1'b0;
			payload_length_q  <= '0;
			bytes_remaining_q <= '0;
			mask_key_q        <= 32'd0;
			mask_pos_q        <= 2'd0;
		end else if (advance_s1) begin
			phase_q           <= phase_d;
			final_flag_q      <= final_flag_d;
			frame_code_q      <= frame_code_d;
			hdr_count_q       <= hdr_count_d;
			ext_wide_q        <= ext_wide_d;
			payload_length_q  <= payload_length_d;
			bytes_remaining_q <= bytes_remaining_d;
			mask_key_q        <= mask_key_d;
			mask_pos_q        <= mask_pos_d;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance_s1 && res_hit) begin
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res_hit) begin
			kind_s2         <= res_kind;
			payload_byte_s2 <= res_byte;
			fin_s2          <= final_flag_d;
			opcode_s2       <= frame_code_d;
			last_s2         <= res_last;
			frame_length_s2 <= res_length;
		end
	end

	assign result_valid = result_valid_s2;
	assign kind         = kind_s2;
	assign payload_byte = payload_byte_s2;
	assign fin          = fin_s2;
	assign opcode       = opcode_s2;
	assign last         = last_s2;
	assign frame_length = frame_length_s2;

endmodule

`default_nettype wire

// ===== hdl/wsd_checker.sv =====
`default_nettype none

module wsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  payload_byte,
	input wire logic        last,
	input wire logic [63:0] frame_length
);

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind)
			&& $stable(payload_byte) && $stable(last) && $stable(frame_length))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (kind == wsd_pkg::KIND_PAYLOAD || kind == wsd_pkg::KIND_EMPTY
			|| kind == wsd_pkg::KIND_ERROR))
		else $error("bad result kind");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != wsd_pkg::KIND_PAYLOAD |-> payload_byte == 8'd0)
		else $error("non-payload result carries data");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == wsd_pkg::KIND_EMPTY || kind == wsd_pkg::KIND_ERROR)
			|-> last && frame_length == 64'd0)
		else $error("empty or error result not final or has length");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == wsd_pkg::KIND_PAYLOAD |-> frame_length != 64'd0)
		else $error("payload byte in zero-length frame");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.kind         (kind),
	.payload_byte (payload_byte),
	.last         (last),
	.frame_length (frame_length)
);

`default_nettype wire

// ===== sim/websocket_frame_deframer_tb.sv =====
module websocket_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Ways to encode the payload length in the header
	typedef enum int {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	// One result beat as the deframer should present it
	typedef struct {
		wsd_pkg::kind_t kind;
		logic [7:0]     data;
		logic           fin;
		logic [3:0]     opcode;
		logic           last;
		logic [63:0]    length;
	} frame_result_t;

	localparam int DRAIN_CYCLES     = 6;    // each result passes the input and result registers
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RANDOM_BEATS     = 800;
	localparam int TOTAL_BEATS      = 950;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        byte_valid     = 1'b0;
	logic        byte_ready;
	logic        new_connection = 1'b0;
	logic [7:0]  link_byte      = 8'h00;
	logic        result_valid;
	logic        result_ready   = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic        fin;
	logic [3:0]  opcode;
	logic        last;
	logic [63:0] frame_length;

	// Traffic shaping shared by the sender, the receiver and the tests
	logic idle_on       = 1'b0;
	logic long_hold_req = 1'b0;
	int   beats_counted = 0;
	int   failures      = 0;

	// Results the deframer still owes us, oldest first
	frame_result_t pending_frame_results[$];

	// Parser state as we track it on our side
	wsd_pkg::phase_t rx_phase;
	logic        rx_fin;
	logic [3:0]  rx_opcode;
	logic [2:0]  rx_hdr_count;
	logic        rx_wide;
	logic [63:0] rx_length;
	logic [63:0] rx_remaining;
	logic [31:0] rx_key;
	logic [1:0]  rx_key_pos;

	websocket_frame_deframer #(
		.LENGTH_BITS(64)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.new_connection(new_connection),
		.link_byte(link_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.fin(fin),
		.opcode(opcode),
		.last(last),
		.frame_length(frame_length)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Drop back to a frame start with nothing decoded
	function void clear_parser();
		rx_phase     = wsd_pkg::PH_FIRST;
		rx_fin       = 1'b0;
		rx_opcode    = 4'h0;
		rx_hdr_count = 3'd0;
		rx_wide      = 1'b0;
		rx_length    = 64'd0;
		rx_remaining = 64'd0;
		rx_key       = 32'd0;
		rx_key_pos   = 2'd0;
	endfunction

	function void push_result(wsd_pkg::kind_t k, logic [7:0] d, logic l, logic [63:0] len);
		frame_result_t r;
		r.kind   = k;
		r.data   = d;
		r.fin    = rx_fin;
		r.opcode = rx_opcode;
		r.last   = l;
		r.length = len;
		pending_frame_results = {pending_frame_results, r};
	endfunction

	// Advance the parser by one accepted beat and queue the result it owes
	function void parse_link_byte(logic restart, logic [7:0] b);
		logic [7:0] key_byte;
		logic       is_last;
		if (restart)
			clear_parser();
		case (rx_phase)
			wsd_pkg::PH_SECOND: begin
				rx_hdr_count = 3'd0;
				if ((b & wsd_pkg::MASK_BIT) == 8'h00) begin
					// unmasked frame: flag it once, then go deaf until a restart
					rx_phase = wsd_pkg::PH_HALTED;
					push_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b1, 64'd0);
				end else if (b[6:0] <= wsd_pkg::LEN7_MAX) begin
					rx_length = {57'd0, b[6:0]};
					rx_phase  = wsd_pkg::PH_KEY;
				end else begin
					rx_length = 64'd0;
					rx_wide   = (b[6:0] == wsd_pkg::LEN7_EXT64);
					rx_phase  = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				rx_length    = {rx_length[55:0], b};
				rx_hdr_count = rx_hdr_count + 3'd1;
				// eight length bytes wrap the 3-bit count back to zero
				if (rx_hdr_count == (rx_wide ? wsd_pkg::EXT64_WRAP
						: wsd_pkg::EXT16_BYTES)) begin
					rx_hdr_count = 3'd0;
					rx_phase     = wsd_pkg::PH_KEY;
				end
			end
			wsd_pkg::PH_KEY: begin
				rx_key       = {rx_key[23:0], b};
				rx_hdr_count = rx_hdr_count + 3'd1;
				if (rx_hdr_count == wsd_pkg::KEY_BYTES) begin
					rx_hdr_count = 3'd0;
					rx_remaining = rx_length;
					rx_key_pos   = 2'd0;
					if (rx_length == 64'd0) begin
						rx_phase = wsd_pkg::PH_FIRST;
						push_result(wsd_pkg::KIND_EMPTY, 8'h00, 1'b1, 64'd0);
					end else begin
						rx_phase = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				key_byte     = rx_key[8 * (3 - int'(rx_key_pos)) +: 8];
				rx_remaining = rx_remaining - 64'd1;
				rx_key_pos   = rx_key_pos + 2'd1;
				is_last      = (rx_remaining == 64'd0);
				if (is_last)
					rx_phase = wsd_pkg::PH_FIRST;
				push_result(wsd_pkg::KIND_PAYLOAD, b ^ key_byte, is_last, rx_length);
			end
			wsd_pkg::PH_HALTED: begin
			end
			default: begin
				rx_fin    = b[7];
				rx_opcode = b[3:0] & wsd_pkg::OPCODE_MASK;
				rx_phase  = wsd_pkg::PH_SECOND;
			end
		endcase
	endfunction

	// Offer one beat, hold it until accepted, then predict what it causes.
	// Valid is only lowered when an idle burst is inserted ahead of the beat.
	task automatic send_beat(input logic restart, input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid     <= 1'b1;
		new_connection <= restart;
		link_byte      <= b;
		do begin
			@(posedge clk);
		end while (!byte_ready);
		beats_counted++;
		parse_link_byte(restart, b);
	endtask

	// Send a masked frame header, key and the first payload_beats bytes
	task automatic send_frame(input logic restart, input logic [7:0] head,
			input logic [63:0] len, input len_form_t form, input logic [31:0] key,
			input int payload_beats);
		send_beat(restart, head);
		case (form)
			FORM_SHORT: begin
				send_beat(1'b0, wsd_pkg::MASK_BIT | {1'b0, len[6:0]});
			end
			FORM_EXT16: begin
				send_beat(1'b0, wsd_pkg::MASK_BIT | {1'b0, wsd_pkg::LEN7_EXT16});
				send_beat(1'b0, len[15:8]);
				send_beat(1'b0, len[7:0]);
			end
			default: begin
				send_beat(1'b0, wsd_pkg::MASK_BIT | {1'b0, wsd_pkg::LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					send_beat(1'b0, len[8 * i +: 8]);
			end
		endcase
		for (int i = 3; i >= 0; i--)
			send_beat(1'b0, key[8 * i +: 8]);
		for (int i = 0; i < payload_beats; i++)
			send_beat(1'b0, 8'($urandom));
	endtask

	// Unmasked header followed by bytes the parser must ignore
	task automatic send_unmasked(input logic restart, input logic [7:0] head,
			input logic [6:0] len7, input int noise_beats);
		send_beat(restart, head);
		send_beat(1'b0, {1'b0, len7});
		for (int i = 0; i < noise_beats; i++)
			send_beat(1'b0, 8'($urandom));
	endtask

	// Complete well-formed frame, mostly short, now and then the longest forms
	task automatic send_random_frame(input logic restart);
		logic [63:0] len;
		len_form_t   form;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 60)
			len = 64'($urandom_range(0, 8));
		else if (r < 88)
			len = 64'($urandom_range(9, 40));
		else if (r < 93)
			len = 64'd125;
		else if (r < 97)
			len = 64'($urandom_range(41, 124));
		else
			len = 64'($urandom_range(126, 260));
		r = $urandom_range(0, 99);
		if (len > 64'd125)
			form = (r < 50) ? FORM_EXT16 : FORM_EXT64;
		else if (r < 70)
			form = FORM_SHORT;
		else if (r < 85)
			form = FORM_EXT16;
		else
			form = FORM_EXT64;
		send_frame(restart, 8'($urandom), len, form, $urandom, int'(len));
	endtask

	// Park the sender until the deframer has delivered everything it owes
	task automatic wait_for_results();
		byte_valid <= 1'b0;
		while (pending_frame_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Empty frame with all header bits set, then an unmasked frame and its fallout
	task automatic test_empty_and_error();
		send_frame(1'b1, 8'hFF, 64'd0, FORM_SHORT, 32'hFFFF_FFFF, 0);
		send_unmasked(1'b0, 8'h00, 7'h7F, 2);
		// restart out of the halted state straight into an empty frame
		send_frame(1'b1, 8'h8A, 64'd0, FORM_EXT16, 32'h0000_0000, 0);
		wait_for_results();
	endtask

	// Non-minimal and top-bit-set extended lengths
	task automatic test_length_forms();
		send_frame(1'b0, 8'h81, 64'd2, FORM_EXT16, 32'hA5C3_0F96, 2);
		send_frame(1'b0, 8'h09, 64'hFFFF_FFFF_FFFF_FFFF, FORM_EXT64, 32'h0123_4567, 2);
		send_frame(1'b1, 8'h82, 64'd1, FORM_EXT64, 32'h8000_0001, 1);
		wait_for_results();
	endtask

	// New connection mid-payload and on the second header byte
	task automatic test_restart();
		send_frame(1'b0, 8'h01, 64'd6, FORM_SHORT, 32'h0102_0304, 3);
		send_beat(1'b1, 8'h8F);
		send_frame(1'b1, 8'h80, 64'd1, FORM_SHORT, 32'hDEAD_BEEF, 1);
		wait_for_results();
	endtask

	// Stall the receiver for a long stretch while payload keeps coming
	task automatic test_backpressure();
		idle_on       = 1'b0;
		long_hold_req = 1'b1;
		send_frame(1'b0, 8'h82, 64'd40, FORM_SHORT, $urandom, 40);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	// Mostly good frames, with aborts, unmasked frames and torn headers mixed in
	task automatic test_random_traffic();
		logic need_restart;
		int   pick;
		need_restart = 1'b0;
		while (beats_counted < RANDOM_BEATS) begin
			// alternate stretches with and without idling
			if ($urandom_range(0, 9) == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_random_frame(need_restart || $urandom_range(0, 19) == 0);
				need_restart = 1'b0;
			end else if (pick < 85) begin
				send_frame(need_restart, 8'($urandom), {$urandom, $urandom}, FORM_EXT64,
					$urandom, $urandom_range(1, 4));
				need_restart = 1'b1;
			end else if (pick < 88) begin
				send_frame(need_restart, 8'($urandom), 64'($urandom_range(300, 65535)),
					FORM_EXT16, $urandom, $urandom_range(1, 4));
				need_restart = 1'b1;
			end else if (pick < 94) begin
				send_unmasked(need_restart, 8'($urandom), 7'($urandom),
					$urandom_range(0, 6));
				need_restart = 1'b1;
			end else begin
				// torn header: a few raw bytes, then abandon the frame
				send_beat(1'b1, 8'($urandom));
				repeat ($urandom_range(0, 4)) send_beat(1'b0, 8'($urandom));
				need_restart = 1'b1;
			end
		end
		if (need_restart)
			send_random_frame(1'b1);
		wait_for_results();
	endtask

	// Back-to-back frames with no idling on either side
	task automatic test_steady_stream();
		idle_on = 1'b0;
		while (beats_counted < TOTAL_BEATS)
			send_random_frame(1'b0);
		wait_for_results();
	endtask

	function void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// Receiver: random short stalls, plus one long hold when a test asks for it
	initial begin : result_sink
		int stall_left;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_ready <= 1'b0;
				stall_left = LONG_HOLD_CYCLES;
				while (stall_left > 0) begin
					@(posedge clk);
					stall_left--;
				end
				result_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Match every result beat against the oldest outstanding prediction
	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_frame_results.size() == 0) begin
				$error("unexpected result: kind %0d, payload_byte %0h, last %0b",
					kind, payload_byte, last);
				failures++;
			end else begin
				want = pending_frame_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(kind));
				check_field("payload_byte", 64'(want.data), 64'(payload_byte));
				check_field("fin", 64'(want.fin), 64'(fin));
				check_field("opcode", 64'(want.opcode), 64'(opcode));
				check_field("last", 64'(want.last), 64'(last));
				check_field("frame_length", want.length, frame_length);
			end
		end
	end

	initial begin
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		test_empty_and_error();
		test_length_forms();
		test_restart();
		test_backpressure();
		test_random_traffic();
		test_steady_stream();

		if (failures == 0 && pending_frame_results.size() == 0)
			$display("websocket_frame_deframer_tb: PASS");
		else
			$display("websocket_frame_deframer_tb: FAIL");
		$finish;
	end

	// Hard stop in case the deframer hangs or loses a result
	initial begin
		#10ms;
		$display("websocket_frame_deframer_tb: FAIL");
		$finish;
	end

endmodule
